// ===== src/psi_section_filter_defines.svh =====
// Assertion macros shared by the section filter checker.
// No dependencies; included by files that carry concurrent assertions.
`ifndef PSI_SECTION_FILTER_DEFINES_SVH
`define PSI_SECTION_FILTER_DEFINES_SVH

// Checked on every rising clock edge once reset has been released.
`define PSF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every rising clock edge, during reset as well.
`define PSF_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== src/psf_pkg.sv =====
// Shared types, constants and helper functions of the PSI section filter.
// No dependencies; compiled before the interfaces and the modules.
package psf_pkg;

    localparam int unsigned PSF_MAX_BUFFER_BYTES = 4096;
    localparam int unsigned LEN_W                = 13;
    localparam int unsigned BYTE_W               = 8;
    localparam int unsigned APB_ADDR_W           = 6;
    localparam int unsigned APB_DATA_W           = 64;

    // Register indexes (byte address is 8 times the index).
    localparam logic [2:0] REG_ID_ENABLE_0    = 3'd0;
    localparam logic [2:0] REG_ID_ENABLE_1    = 3'd1;
    localparam logic [2:0] REG_ID_ENABLE_2    = 3'd2;
    localparam logic [2:0] REG_ID_ENABLE_3    = 3'd3;
    localparam logic [2:0] REG_MIN_BUF_BYTES  = 3'd4;

    // Reset values of the configuration registers.
    localparam logic [63:0]      ID_ENABLE_0_RST = 64'd5;
    localparam logic [63:0]      ID_ENABLE_1_RST = 64'd2814749767091271;
    localparam logic [63:0]      ID_ENABLE_2_RST = 64'd0;
    localparam logic [63:0]      ID_ENABLE_3_RST = 64'd0;
    localparam logic [LEN_W-1:0] MIN_BUF_RST     = 13'd3;

    // Section syntax constants.
    localparam logic [BYTE_W-1:0] TABLE_ID_STOP  = 8'hFF;
    localparam logic [3:0]        LEN_HI_MASK    = 4'hF;
    localparam logic [LEN_W-1:0]  HEADER_BYTES   = 13'd3;

    typedef logic [LEN_W-1:0]  len_t;
    typedef logic [BYTE_W-1:0] byte_t;

    typedef struct packed {
        byte_t out_byte;
        byte_t section_table_id;
        logic  section_first;
        logic  section_last;
        logic  section_truncated;
    } psf_result_t;

    // Looks up the enable bit of a table id in the 256-bit map.
    function automatic logic id_enabled(input logic [63:0] en0, input logic [63:0] en1,
                                        input logic [63:0] en2, input logic [63:0] en3,
                                        input byte_t id);
        logic [63:0] word;
        case (id[7:6])
            2'd0:    word = en0;
            2'd1:    word = en1;
            2'd2:    word = en2;
            2'd3:    word = en3;
            default: word = en0;
        endcase
        return word[id[5:0]];
    endfunction

endpackage

// ===== src/psf_in_if.sv =====
// Input channel of the PSI section filter: one buffer byte per word.
// Depends on psf_pkg for the field widths.
interface psf_in_if;
    import psf_pkg::*;

    logic  valid;
    logic  ready;
    byte_t data_byte;
    len_t  buffer_length;
    logic  buffer_start;

    modport source (output valid, output data_byte, output buffer_length,
                    output buffer_start, input ready);
    modport sink   (input valid, input data_byte, input buffer_length,
                    input buffer_start, output ready);
endinterface

// ===== src/psf_out_if.sv =====
// Output channel of the PSI section filter: one tagged section byte per word.
// Depends on psf_pkg for the field widths.
interface psf_out_if;
    import psf_pkg::*;

    logic  valid;
    logic  ready;
    byte_t out_byte;
    byte_t section_table_id;
    logic  section_first;
    logic  section_last;
    logic  section_truncated;

    modport source (output valid, output out_byte, output section_table_id,
                    output section_first, output section_last,
                    output section_truncated, input ready);
    modport sink   (input valid, input out_byte, input section_table_id,
                    input section_first, input section_last,
                    input section_truncated, output ready);
endinterface

// ===== src/psi_section_filter.sv =====
// PSI section filter: splits section buffers into sections and passes enabled ones.
// A result word is registered and appears in the cycle after its input word is accepted.
// Throughput: one input word per cycle; the only stall is a full output register
// whose word is not being taken in the same cycle.
// Reset (rst_n, asynchronous, active low) clears parser state and output valid.
// Depends on psf_pkg, psf_in_if and psf_out_if; register defaults come from psf_pkg.
module psi_section_filter
    import psf_pkg::*;
#(
    parameter int unsigned MAX_BUFFER_BYTES = PSF_MAX_BUFFER_BYTES
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    psf_in_if.sink                sec_in,
    psf_out_if.source             sec_out,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    // Clamp value for the buffer length. Held one bit wider so that a maximum of
    // 8192 still compares correctly against the 13-bit length field.
    localparam logic [LEN_W:0] MAX_LEN_WIDE = (LEN_W+1)'(MAX_BUFFER_BYTES);

    // ------------------------------------------------------------------
    // Configuration registers on the APB port. pready is tied high, so a
    // write lands at the edge of its access cycle.
    // ------------------------------------------------------------------
    logic [63:0] id_en0_reg;
    logic [63:0] id_en1_reg;
    logic [63:0] id_en2_reg;
    logic [63:0] id_en3_reg;
    len_t        min_buf_reg;
    logic        cfg_write;
    logic [2:0]  cfg_index;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = paddr[5:3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            id_en0_reg  <= ID_ENABLE_0_RST;
            id_en1_reg  <= ID_ENABLE_1_RST;
            id_en2_reg  <= ID_ENABLE_2_RST;
            id_en3_reg  <= ID_ENABLE_3_RST;
            min_buf_reg <= MIN_BUF_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_ID_ENABLE_0:   id_en0_reg  <= pwdata;
                REG_ID_ENABLE_1:   id_en1_reg  <= pwdata;
                REG_ID_ENABLE_2:   id_en2_reg  <= pwdata;
                REG_ID_ENABLE_3:   id_en3_reg  <= pwdata;
                REG_MIN_BUF_BYTES: min_buf_reg <= pwdata[LEN_W-1:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_index)
            REG_ID_ENABLE_0:   prdata = id_en0_reg;
            REG_ID_ENABLE_1:   prdata = id_en1_reg;
            REG_ID_ENABLE_2:   prdata = id_en2_reg;
            REG_ID_ENABLE_3:   prdata = id_en3_reg;
            REG_MIN_BUF_BYTES: prdata = {{(APB_DATA_W-LEN_W){1'b0}}, min_buf_reg};
            default:           prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Parser state. It advances only on an accepted input word.
    // ------------------------------------------------------------------
    len_t  buf_index_reg,  buf_index_next;
    len_t  buf_len_reg,    buf_len_next;
    len_t  sec_pos_reg,    sec_pos_next;
    len_t  sec_total_reg,  sec_total_next;
    byte_t cur_id_reg,     cur_id_next;
    logic  sec_acc_reg,    sec_acc_next;
    logic  buf_stop_reg,   buf_stop_next;

    // Output register, which lets the next input word in while the waiting result is taken.
    logic        out_valid_reg, out_valid_next;
    psf_result_t result_reg,    result_next;

    logic in_fire;
    logic active;
    logic is_stop;
    logic end_sec;
    logic end_buf;
    logic emit;
    len_t pos;
    len_t clamped_len;

    assign sec_in.ready = !out_valid_reg || sec_out.ready;
    assign in_fire      = sec_in.valid && sec_in.ready;

    always_comb
    begin
        // The buffer length is clamped to the configured maximum buffer size.
        if ({1'b0, sec_in.buffer_length} > MAX_LEN_WIDE)
        begin
            clamped_len = MAX_LEN_WIDE[LEN_W-1:0];
        end
        else
        begin
            clamped_len = sec_in.buffer_length;
        end

        // A buffer start word restarts the parser before the byte is looked at.
        if (sec_in.buffer_start)
        begin
            buf_index_next = '0;
            buf_len_next   = clamped_len;
            sec_pos_next   = '0;
            sec_total_next = '0;
            sec_acc_next   = 1'b0;
            buf_stop_next  = (sec_in.buffer_length < min_buf_reg);
        end
        else
        begin
            buf_index_next = buf_index_reg;
            buf_len_next   = buf_len_reg;
            sec_pos_next   = sec_pos_reg;
            sec_total_next = sec_total_reg;
            sec_acc_next   = sec_acc_reg;
            buf_stop_next  = buf_stop_reg;
        end
        cur_id_next = cur_id_reg;

        // Bytes past the buffer end, or after a stop id, are discarded.
        active  = !buf_stop_next && (buf_index_next < buf_len_next);
        pos     = sec_pos_next;
        is_stop = (pos == '0) && (sec_in.data_byte == TABLE_ID_STOP);
        emit    = 1'b0;
        end_sec = 1'b0;
        end_buf = 1'b0;

        if (active)
        begin
            if (is_stop)
            begin
                buf_stop_next = 1'b1;
            end
            else
            begin
                if (pos == '0)
                begin
                    cur_id_next  = sec_in.data_byte;
                    sec_acc_next = id_enabled(id_en0_reg, id_en1_reg, id_en2_reg,
                                              id_en3_reg, sec_in.data_byte);
                end
                else if (pos == len_t'(1))
                begin
                    sec_total_next = {1'b0, sec_in.data_byte[3:0] & LEN_HI_MASK, 8'h00};
                end
                else if (pos == len_t'(2))
                begin
                    // The section length fits 12 bits, so adding the header cannot wrap.
                    sec_total_next = (sec_total_next | {5'd0, sec_in.data_byte})
                                     + HEADER_BYTES;
                end

                end_sec = (pos >= len_t'(2)) && ((pos + len_t'(1)) == sec_total_next);
                end_buf = ((buf_index_next + len_t'(1)) == buf_len_next);

                buf_index_next = buf_index_next + len_t'(1);
                sec_pos_next   = end_sec ? '0 : (pos + len_t'(1));
                emit           = sec_acc_next;
            end
        end

        result_next.out_byte          = sec_in.data_byte;
        result_next.section_table_id  = cur_id_next;
        result_next.section_first     = (pos == '0);
        result_next.section_last      = end_sec || end_buf;
        result_next.section_truncated = end_buf && !end_sec;

        if (in_fire)
        begin
            out_valid_next = emit;
        end
        else if (sec_out.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_index_reg <= '0;
            buf_len_reg   <= '0;
            sec_pos_reg   <= '0;
            sec_total_reg <= '0;
            cur_id_reg    <= '0;
            sec_acc_reg   <= 1'b0;
            buf_stop_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (in_fire)
            begin
                buf_index_reg <= buf_index_next;
                buf_len_reg   <= buf_len_next;
                sec_pos_reg   <= sec_pos_next;
                sec_total_reg <= sec_total_next;
                cur_id_reg    <= cur_id_next;
                sec_acc_reg   <= sec_acc_next;
                buf_stop_reg  <= buf_stop_next;
            end
        end
    end

    // The payload register is loaded only when a new result is captured.
    always_ff @(posedge clk)
    begin
        if (in_fire && emit)
        begin
            result_reg <= result_next;
        end
    end

    assign sec_out.valid             = out_valid_reg;
    assign sec_out.out_byte          = result_reg.out_byte;
    assign sec_out.section_table_id  = result_reg.section_table_id;
    assign sec_out.section_first     = result_reg.section_first;
    assign sec_out.section_last      = result_reg.section_last;
    assign sec_out.section_truncated = result_reg.section_truncated;

endmodule

// ===== src/psf_checker.sv =====
// Port-level assertions for the PSI section filter, bound to the top level.
// Depends on psi_section_filter_defines.svh for the assertion macros and on psf_pkg.
`include "psi_section_filter_defines.svh"

module psf_checker
    import psf_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic [7:0] section_table_id,
    input logic       section_last,
    input logic       section_truncated
);

    // A word on offer must stay until it is taken, with its data byte unchanged.
    `PSF_ASSERT(a_out_hold, (out_valid && !out_ready) |=> (out_valid && $stable(out_byte)), "output word dropped or changed while stalled")

    // With an empty output register the input side is never stalled.
    `PSF_ASSERT(a_in_ready_when_empty, !out_valid |-> in_ready, "input stalled with empty output register")

    // The stop id never belongs to a section that is passed on.
    `PSF_ASSERT(a_no_stop_id, out_valid |-> (section_table_id != TABLE_ID_STOP), "stop table id appeared on output")

    // A truncated section is always closed on the same word.
    `PSF_ASSERT(a_trunc_is_last, (out_valid && section_truncated) |-> section_last, "truncated word without last mark")

    // No result is shown while reset is held.
    `PSF_ASSERT_ALWAYS(a_reset_quiet, !rst_n |-> !out_valid, "output valid during reset")

endmodule

bind psi_section_filter psf_checker u_psf_checker
(
    .clk               (clk),
    .rst_n             (rst_n),
    .in_ready          (sec_in.ready),
    .out_valid         (sec_out.valid),
    .out_ready         (sec_out.ready),
    .out_byte          (sec_out.out_byte),
    .section_table_id  (sec_out.section_table_id),
    .section_last      (sec_out.section_last),
    .section_truncated (sec_out.section_truncated)
);
